/* src/scsa_pkg.sv */
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, constants and helpers for the size class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

  localparam int ADDR_W      = 17;
  localparam int SIZE_W      = 16;
  localparam int STATUS_W    = 2;
  localparam int POOL_W      = 3;
  localparam int NUM_POOLS   = 7;
  localparam int SLOT_IDX_W  = 10;
  localparam int COUNT_W     = 11;
  localparam int LINK_W      = SLOT_IDX_W + 1;
  localparam int DIV3_IN_W   = 12;
  localparam int DIV3_PROD_W = 28;
  localparam int DIV3_SHIFT  = 17;

  localparam logic [15:0] DIV3_RECIP = 16'd43691;

  localparam int DEF_SLOTS_SMALL = 1024;
  localparam int DEF_SLOTS_MID   = 512;
  localparam int DEF_SLOTS_LARGE = 256;
  localparam int DEF_SLOTS_HUGE  = 128;

  localparam int MAX_SLOT_BYTES = 256;

  localparam int SLOT_BYTES [NUM_POOLS] = '{8, 16, 24, 32, 48, 64, 256};
  // slot = (offset >> SLOT_SHIFT) / (SLOT_DIV3 ? 3 : 1)
  localparam int SLOT_SHIFT [NUM_POOLS] = '{3, 4, 3, 5, 4, 6, 8};
  localparam bit SLOT_DIV3  [NUM_POOLS] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  localparam logic              MODE_ALLOC = 1'b0;
  localparam logic              MODE_FREE  = 1'b1;
  localparam logic [POOL_W-1:0] POOL_NONE  = 3'd7;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK         = 2'd0,
    STAT_TOO_LARGE  = 2'd1,
    STAT_EXHAUSTED  = 2'd2,
    STAT_NOT_POOLED = 2'd3
  } status_t;

  typedef struct packed {
    logic                  hit;
    logic [POOL_W-1:0]     pool;
    logic [SLOT_IDX_W-1:0] slot;
  } free_dec_t;

  function automatic int pool_slots(int p, int ss, int sm, int sl, int sh);
    case (p)
      0:       return ss;
      1, 2, 3: return sm;
      4, 5:    return sl;
      default: return sh;
    endcase
  endfunction

  function automatic int pool_base(int p, int ss, int sm, int sl, int sh);
    int b;
    b = 0;
    for (int i = 0; i < p; i++) b += pool_slots(i, ss, sm, sl, sh) * SLOT_BYTES[i];
    return b;
  endfunction

  function automatic int link_base(int p, int ss, int sm, int sl, int sh);
    int b;
    b = 0;
    for (int i = 0; i < p; i++) b += pool_slots(i, ss, sm, sl, sh);
    return b;
  endfunction

  // exact floor(x / 3) for x below 3072
  function automatic logic [SLOT_IDX_W-1:0] div3(input logic [DIV3_IN_W-1:0] x);
    logic [DIV3_PROD_W-1:0] prod;
    prod = DIV3_PROD_W'(x) * DIV3_PROD_W'(DIV3_RECIP);
    return prod[DIV3_SHIFT +: SLOT_IDX_W];
  endfunction

endpackage

/* src/scsa_if.sv */
// ----------------------------------------------------------------------------
// scsa_req_if / scsa_rsp_if
// Valid/ready channels for allocator requests and responses.
// ----------------------------------------------------------------------------
interface scsa_req_if import scsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [SIZE_W-1:0] request_size;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, output mode, output request_size, output free_address,
                  input ready);
  modport sink   (input valid, input mode, input request_size, input free_address,
                  output ready);
endinterface

interface scsa_rsp_if import scsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   slot_address;
  logic [STATUS_W-1:0] status;
  logic [POOL_W-1:0]   pool_index;

  modport source (output valid, output slot_address, output status, output pool_index,
                  input ready);
  modport sink   (input valid, input slot_address, input status, input pool_index,
                  output ready);
endinterface

/* src/scsa_free_decode.sv */
// ----------------------------------------------------------------------------
// scsa_free_decode
// Maps a byte address to the pool and slot that contain it.
// ----------------------------------------------------------------------------
module scsa_free_decode import scsa_pkg::*; #(
  parameter int SLOTS_SMALL = DEF_SLOTS_SMALL,
  parameter int SLOTS_MID   = DEF_SLOTS_MID,
  parameter int SLOTS_LARGE = DEF_SLOTS_LARGE,
  parameter int SLOTS_HUGE  = DEF_SLOTS_HUGE
) (
  input  logic [ADDR_W-1:0] free_address,
  output free_dec_t         dec
);

  localparam int TOTAL_BYTES =
    pool_base(NUM_POOLS, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE);
  localparam int BYTE_W = $clog2(TOTAL_BYTES + 1);
  localparam int SPAN_W = (BYTE_W > ADDR_W) ? BYTE_W : ADDR_W;

  localparam int BASE_I [NUM_POOLS] = '{
    pool_base(0, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(1, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(2, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(3, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(4, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(5, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(6, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE)
  };
  localparam int SPAN_I [NUM_POOLS] = '{
    SLOTS_SMALL * SLOT_BYTES[0], SLOTS_MID * SLOT_BYTES[1], SLOTS_MID * SLOT_BYTES[2],
    SLOTS_MID * SLOT_BYTES[3], SLOTS_LARGE * SLOT_BYTES[4], SLOTS_LARGE * SLOT_BYTES[5],
    SLOTS_HUGE * SLOT_BYTES[6]
  };

  logic [SPAN_W-1:0] addr_x;

  assign addr_x = SPAN_W'(free_address);

  always_comb begin
    logic [SPAN_W-1:0] off;
    dec = '0;
    for (int p = 0; p < NUM_POOLS; p++) begin
      off = addr_x - SPAN_W'(BASE_I[p]);
      if (!dec.hit && addr_x >= SPAN_W'(BASE_I[p]) && off < SPAN_W'(SPAN_I[p])) begin
        dec.hit  = 1'b1;
        dec.pool = POOL_W'(p);
        if (SLOT_DIV3[p]) begin
          dec.slot = div3(DIV3_IN_W'(off >> SLOT_SHIFT[p]));
        end else begin
          dec.slot = SLOT_IDX_W'(off >> SLOT_SHIFT[p]);
        end
      end
    end
  end

endmodule

/* src/size_class_slab_allocator.sv */
// ----------------------------------------------------------------------------
// size_class_slab_allocator
// Seven-pool slab allocator: allocate pops a free list or bumps a count,
// free pushes the decoded slot onto its pool's free list.
// ----------------------------------------------------------------------------
// Response: an accepted request moves the state to S_EXEC, and when S_EXEC
//   commits the result is written into the response register.
// Requests are taken only in S_IDLE, once the last one commits; the link-store
//   read issued at acceptance is used in S_EXEC to update the pool state.
// The response register lets the next request in while a response waits;
//   that request holds in S_EXEC until the register frees.
// Reset (synchronous, rst_n low): counts zero, free lists empty. The link
//   store is not cleared; entries are written before they are read.
module size_class_slab_allocator import scsa_pkg::*; #(
  parameter int SLOTS_SMALL = DEF_SLOTS_SMALL,
  parameter int SLOTS_MID   = DEF_SLOTS_MID,
  parameter int SLOTS_LARGE = DEF_SLOTS_LARGE,
  parameter int SLOTS_HUGE  = DEF_SLOTS_HUGE
) (
  input  logic       clk,
  input  logic       rst_n,
  scsa_req_if.sink   in_req,
  scsa_rsp_if.source out_rsp
);

  localparam int LINK_DEPTH =
    link_base(NUM_POOLS, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE);
  localparam int LI_W = $clog2(LINK_DEPTH);

  localparam int SLOTS_I [NUM_POOLS] = '{
    SLOTS_SMALL, SLOTS_MID, SLOTS_MID, SLOTS_MID, SLOTS_LARGE, SLOTS_LARGE, SLOTS_HUGE
  };
  localparam int BASE_I [NUM_POOLS] = '{
    pool_base(0, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(1, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(2, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(3, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(4, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(5, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    pool_base(6, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE)
  };
  localparam int LBASE_I [NUM_POOLS] = '{
    link_base(0, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    link_base(1, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    link_base(2, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    link_base(3, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    link_base(4, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    link_base(5, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE),
    link_base(6, SLOTS_SMALL, SLOTS_MID, SLOTS_LARGE, SLOTS_HUGE)
  };

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t                state_r;
  logic [COUNT_W-1:0]    bump_count_r [NUM_POOLS];
  logic [SLOT_IDX_W-1:0] free_head_r  [NUM_POOLS];
  logic                  head_valid_r [NUM_POOLS];

  logic                  mode_r;
  logic                  too_large_r;
  logic                  hit_r;
  logic [POOL_W-1:0]     pool_r;
  logic [SLOT_IDX_W-1:0] fslot_r;
  logic [LI_W-1:0]       wr_idx_r;

  logic [LINK_W-1:0]     link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]     rd_data_r;

  logic                  out_valid_r;
  logic [ADDR_W-1:0]     out_addr_r;
  status_t               out_status_r;
  logic [POOL_W-1:0]     out_pool_r;

  // acceptance side
  logic                  in_fire;
  logic                  too_large_a;
  logic [POOL_W-1:0]     size_pool;
  logic [LI_W-1:0]       rd_addr;
  logic [LI_W-1:0]       wr_idx_nxt;
  logic                  rd_en;
  free_dec_t             fdec;

  // execute side
  logic                  commit;
  logic                  do_pop;
  logic                  do_bump;
  logic                  do_push;
  logic [SLOT_IDX_W-1:0] slot_sel;
  logic [ADDR_W-1:0]     addr_nxt;
  status_t               status_nxt;
  logic [POOL_W-1:0]     pool_nxt;

  scsa_free_decode #(
    .SLOTS_SMALL (SLOTS_SMALL),
    .SLOTS_MID   (SLOTS_MID),
    .SLOTS_LARGE (SLOTS_LARGE),
    .SLOTS_HUGE  (SLOTS_HUGE)
  ) u_free_decode (
    .free_address (in_req.free_address),
    .dec          (fdec)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign in_fire      = in_req.valid & in_req.ready;

  assign too_large_a = (in_req.request_size > SIZE_W'(MAX_SLOT_BYTES));

  always_comb begin
    size_pool = POOL_W'(NUM_POOLS - 1);
    for (int p = NUM_POOLS - 2; p >= 0; p--) begin
      if (in_req.request_size <= SIZE_W'(SLOT_BYTES[p])) size_pool = POOL_W'(p);
    end
  end

  assign rd_addr    = LI_W'(LBASE_I[size_pool]) + LI_W'(free_head_r[size_pool]);
  assign wr_idx_nxt = LI_W'(LBASE_I[fdec.pool]) + LI_W'(fdec.slot);
  assign rd_en      = in_fire && (in_req.mode == MODE_ALLOC) && !too_large_a &&
                      head_valid_r[size_pool];

  assign commit = (state_r == S_EXEC) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    do_pop     = 1'b0;
    do_bump    = 1'b0;
    do_push    = 1'b0;
    slot_sel   = fslot_r;
    status_nxt = STAT_OK;
    pool_nxt   = POOL_NONE;
    if (mode_r == MODE_ALLOC) begin
      if (too_large_r) begin
        status_nxt = STAT_TOO_LARGE;
      end else begin
        pool_nxt = pool_r;
        if (head_valid_r[pool_r]) begin
          do_pop   = 1'b1;
          slot_sel = free_head_r[pool_r];
        end else if (bump_count_r[pool_r] < COUNT_W'(SLOTS_I[pool_r])) begin
          do_bump  = 1'b1;
          slot_sel = bump_count_r[pool_r][SLOT_IDX_W-1:0];
        end else begin
          status_nxt = STAT_EXHAUSTED;
        end
      end
    end else if (hit_r) begin
      do_push  = 1'b1;
      pool_nxt = pool_r;
    end else begin
      status_nxt = STAT_NOT_POOLED;
    end
    if (do_pop || do_bump || do_push) begin
      addr_nxt = ADDR_W'(BASE_I[pool_r]) +
                 ADDR_W'(slot_sel) * ADDR_W'(SLOT_BYTES[pool_r]);
    end else begin
      addr_nxt = '0;
    end
  end

  // link store: read at acceptance, written back on a free
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= link_mem[rd_addr];
    if (commit && do_push) begin
      link_mem[wr_idx_r] <= {head_valid_r[pool_r], free_head_r[pool_r]};
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r      <= in_req.mode;
      too_large_r <= too_large_a;
      hit_r       <= fdec.hit;
      pool_r      <= (in_req.mode == MODE_FREE) ? fdec.pool : size_pool;
      fslot_r     <= fdec.slot;
      wr_idx_r    <= wr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        bump_count_r[p] <= '0;
        free_head_r[p]  <= '0;
        head_valid_r[p] <= 1'b0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (commit) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase

      if (commit) begin
        out_valid_r  <= 1'b1;
        out_addr_r   <= addr_nxt;
        out_status_r <= status_nxt;
        out_pool_r   <= pool_nxt;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end

      if (commit && do_pop) begin
        head_valid_r[pool_r] <= rd_data_r[LINK_W-1];
        free_head_r[pool_r]  <= rd_data_r[SLOT_IDX_W-1:0];
      end
      if (commit && do_bump) begin
        bump_count_r[pool_r] <= bump_count_r[pool_r] + COUNT_W'(1);
      end
      if (commit && do_push) begin
        head_valid_r[pool_r] <= 1'b1;
        free_head_r[pool_r]  <= fslot_r;
      end
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.slot_address = out_addr_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.pool_index   = out_pool_r;

endmodule

/* test/slab_score_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slab_score_pkg
// Predicts the allocator's responses from its own copy of the pool counts,
// free lists and slot links, and checks each response against the oldest
// outstanding prediction, field by field.
// ----------------------------------------------------------------------------
package slab_score_pkg;
  import scsa_pkg::*;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           status;
    logic [POOL_W-1:0] pool;
  } slab_result_t;

  class slab_scoreboard;
    int unsigned         slot_count  [NUM_POOLS];
    int unsigned         byte_base   [NUM_POOLS];
    int unsigned         link_offset [NUM_POOLS];
    int unsigned         byte_end;
    logic [COUNT_W-1:0]  bump_count  [NUM_POOLS];
    logic [SLOT_IDX_W-1:0] list_top  [NUM_POOLS];
    bit                  list_nonempty [NUM_POOLS];
    logic [LINK_W-1:0]   next_link [];
    slab_result_t        awaited_q [$];
    int mismatches, unexpected, checked, reports;
    int n_alloc_ok, n_free_ok, n_too_large, n_exhausted, n_not_pooled;

    function new();
      int unsigned b, l;
      b = 0;
      l = 0;
      for (int p = 0; p < NUM_POOLS; p++) begin
        case (p)
          0:       slot_count[p] = DEF_SLOTS_SMALL;
          1, 2, 3: slot_count[p] = DEF_SLOTS_MID;
          4, 5:    slot_count[p] = DEF_SLOTS_LARGE;
          default: slot_count[p] = DEF_SLOTS_HUGE;
        endcase
        byte_base[p]     = b;
        link_offset[p]   = l;
        b += slot_count[p] * SLOT_BYTES[p];
        l += slot_count[p];
        bump_count[p]    = '0;
        list_top[p]      = '0;
        list_nonempty[p] = 1'b0;
      end
      byte_end  = b;
      next_link = new[l];
    endfunction

    // apply one accepted request to the pool state, queue its response
    function slab_result_t note_request(logic mode, logic [SIZE_W-1:0] size,
                                        logic [ADDR_W-1:0] addr);
      slab_result_t      r;
      int                p;
      int unsigned       slot;
      bit                got;
      logic [LINK_W-1:0] lk;
      r.addr   = '0;
      r.status = STAT_OK;
      r.pool   = POOL_NONE;
      got      = 1'b0;
      slot     = 0;
      if (mode == MODE_ALLOC) begin
        if (size > MAX_SLOT_BYTES) begin
          r.status = STAT_TOO_LARGE;
          n_too_large++;
        end else begin
          p = 0;
          while (p < NUM_POOLS - 1 && size > SLOT_BYTES[p]) p++;
          r.pool = POOL_W'(p);
          if (list_nonempty[p]) begin
            slot             = list_top[p];
            lk               = next_link[link_offset[p] + slot];
            list_nonempty[p] = lk[SLOT_IDX_W];
            list_top[p]      = lk[SLOT_IDX_W-1:0];
            got              = 1'b1;
          end else if (bump_count[p] < slot_count[p]) begin
            slot = bump_count[p];
            bump_count[p]++;
            got = 1'b1;
          end
          if (got) begin
            r.addr = ADDR_W'(byte_base[p] + slot * SLOT_BYTES[p]);
            n_alloc_ok++;
          end else begin
            r.status = STAT_EXHAUSTED;
            n_exhausted++;
          end
        end
      end else begin
        r.status = STAT_NOT_POOLED;
        for (int q = 0; q < NUM_POOLS; q++) begin
          if (!got && addr >= byte_base[q] &&
              addr < byte_base[q] + slot_count[q] * SLOT_BYTES[q]) begin
            slot = (addr - byte_base[q]) / SLOT_BYTES[q];
            next_link[link_offset[q] + slot] = {list_nonempty[q], list_top[q]};
            list_top[q]      = slot[SLOT_IDX_W-1:0];
            list_nonempty[q] = 1'b1;
            r.status = STAT_OK;
            r.pool   = POOL_W'(q);
            r.addr   = ADDR_W'(byte_base[q] + slot * SLOT_BYTES[q]);
            got      = 1'b1;
          end
        end
        if (got) n_free_ok++;
        else n_not_pooled++;
      end
      awaited_q.push_back(r);
      return r;
    endfunction

    function void check_response(logic [ADDR_W-1:0] addr, logic [STATUS_W-1:0] status,
                                 logic [POOL_W-1:0] pool);
      slab_result_t e;
      if (awaited_q.size() == 0) begin
        unexpected++;
        reports++;
        if (reports <= 10)
          $display("error: response with none outstanding: addr %0d status %0d pool %0d",
                   addr, status, pool);
        return;
      end
      e = awaited_q.pop_front();
      checked++;
      if (addr !== e.addr || status !== e.status || pool !== e.pool) begin
        mismatches++;
        reports++;
        if (reports <= 10)
          $display({"error: response %0d: expected addr %0d %s pool %0d, ",
                    "got addr %0d status %0d pool %0d"},
                   checked, e.addr, e.status.name(), e.pool, addr, status, pool);
      end
    endfunction

    function int outstanding();
      return awaited_q.size();
    endfunction

    function int failures();
      return mismatches + unexpected;
    endfunction
  endclass

endpackage

/* test/size_class_slab_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// size_class_slab_allocator_tb
// Drives allocate and free requests into the slab allocator with random
// gaps and response back-pressure. Directed requests hit the size class
// boundaries and free decoding corners; random phases fill pools to
// exhaustion, release slots back and then mix allocations with frees of
// live, unaligned, stray and out-of-range addresses.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_tb;
  import scsa_pkg::*;
  import slab_score_pkg::*;

  localparam int TOTAL_ITEMS = 1050;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    int unsigned       bytes;
  } live_slot_t;

  logic clk;
  logic rst_n;

  scsa_req_if req_ch ();
  scsa_rsp_if rsp_ch ();

  size_class_slab_allocator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  slab_scoreboard sb;
  live_slot_t     live_q [$];
  bit             in_idle  = 1'b1;
  bit             out_idle = 1'b1;
  int             sent = 0;
  int             cycle_count = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, sb.outstanding());
      $display("FAIL size_class_slab_allocator");
      $finish;
    end
  end

  task automatic send_req(input logic mode, input logic [SIZE_W-1:0] size,
                          input logic [ADDR_W-1:0] addr);
    int           gap;
    slab_result_t r;
    gap = in_idle ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.mode         = mode;
    req_ch.request_size = size;
    req_ch.free_address = addr;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    r = sb.note_request(mode, size, addr);
    if (mode == MODE_ALLOC && r.status == STAT_OK)
      live_q.push_back('{r.addr, SLOT_BYTES[r.pool]});
    sent++;
    @(negedge clk);
  endtask

  task automatic alloc_in_pool(input int p);
    int unsigned lo;
    lo = (p == 0) ? 0 : SLOT_BYTES[p-1] + 1;
    send_req(MODE_ALLOC, SIZE_W'($urandom_range(SLOT_BYTES[p], lo)),
             ADDR_W'($urandom_range(131071, 0)));
  endtask

  task automatic random_item(input int alloc_pct);
    int                pick, k;
    logic [ADDR_W-1:0] a;
    live_slot_t        s;
    pick = $urandom_range(9, 0);
    if ($urandom_range(99, 0) < alloc_pct) begin
      if (pick < NUM_POOLS) alloc_in_pool(pick);
      else if (pick == 7)
        send_req(MODE_ALLOC, $urandom_range(1, 0) ? 16'd0 : 16'd256,
                 ADDR_W'($urandom_range(131071, 0)));
      else if (pick == 8) alloc_in_pool(NUM_POOLS - 1);
      else
        send_req(MODE_ALLOC, SIZE_W'($urandom_range(65535, 257)),
                 ADDR_W'($urandom_range(131071, 0)));
    end else begin
      if (pick < 7 && live_q.size() > 0) begin
        k = $urandom_range(live_q.size() - 1, 0);
        s = live_q[k];
        live_q.delete(k);
        a = s.addr;
        if ($urandom_range(3, 0) == 0) a += ADDR_W'($urandom_range(s.bytes - 1, 0));
      end else if (pick == 8) begin
        a = ADDR_W'($urandom_range(131071, sb.byte_end));
      end else if (pick == 9) begin
        a = ADDR_W'($urandom_range(131071, 0));
      end else begin
        a = ADDR_W'($urandom_range(sb.byte_end - 1, 0));
      end
      send_req(MODE_FREE, SIZE_W'($urandom_range(65535, 0)), a);
    end
  endtask

  initial begin : response_sink
    int stall;
    @(posedge rst_n);
    forever begin
      stall = out_idle ? $urandom_range(14, 0) : 0;
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
      sb.check_response(rsp_ch.slot_address, rsp_ch.status, rsp_ch.pool_index);
      @(negedge clk);
    end
  end

  initial begin : request_source
    int sizes [16];
    int blk;
    sizes = '{0, 8, 9, 16, 17, 24, 25, 32, 33, 48, 49, 64, 65, 256, 257, 65535};
    sb = new();
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_ALLOC;
    req_ch.request_size = '0;
    req_ch.free_address = '0;
    rsp_ch.ready        = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // size class boundaries, zero size and oversize
    foreach (sizes[i])
      send_req(MODE_ALLOC, SIZE_W'(sizes[i]), ADDR_W'($urandom_range(131071, 0)));
    // unaligned free, never-used last slot, out of range, double free
    send_req(MODE_FREE, 16'hFFFF, 17'd5);
    send_req(MODE_FREE, 16'h0000, ADDR_W'(sb.byte_end - 1));
    send_req(MODE_FREE, 16'h0000, ADDR_W'(sb.byte_end));
    send_req(MODE_FREE, 16'h0000, 17'h1FFFF);
    send_req(MODE_FREE, 16'h0000, ADDR_W'(sb.byte_base[3] + 7));
    send_req(MODE_FREE, 16'h0000, ADDR_W'(sb.byte_base[3]));
    // pops of the pushed slots
    send_req(MODE_ALLOC, 16'd256, '0);
    send_req(MODE_ALLOC, 16'd1, '0);
    send_req(MODE_ALLOC, 16'd32, '0);

    // run the 256-byte pool past its last slot
    repeat (130) alloc_in_pool(NUM_POOLS - 1);
    req_ch.valid = 1'b0;
    while (sb.outstanding() > 0) @(negedge clk);

    repeat (70) random_item(15);
    // run the 48-byte pool past its last slot
    repeat (262) alloc_in_pool(4);

    blk = 0;
    while (sent < TOTAL_ITEMS) begin
      in_idle  = (blk % 3 != 2);
      out_idle = (blk % 4 != 3);
      repeat (50) random_item((blk % 2 == 0) ? 70 : 35);
      blk++;
    end
    in_idle      = 1'b1;
    out_idle     = 1'b1;
    req_ch.valid = 1'b0;

    while (sb.outstanding() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display({"%0d requests: %0d slots handed out, %0d freed, %0d exhausted, ",
              "%0d too large, %0d unpooled"},
             sent, sb.n_alloc_ok, sb.n_free_ok, sb.n_exhausted, sb.n_too_large,
             sb.n_not_pooled);
    $display("%0d responses checked, %0d mismatches, %0d unexpected, %0d outstanding",
             sb.checked, sb.mismatches, sb.unexpected, sb.outstanding());
    if (sb.failures() == 0 && sb.outstanding() == 0) begin
      $display("PASS size_class_slab_allocator");
    end else begin
      $display("FAIL size_class_slab_allocator");
    end
    $finish;
  end

endmodule
